// ===== hdl/kmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_pkg: shared types and constants for the k-means cluster engine
// request codes, result codes, sequencer states and field widths
// ----------------------------------------------------------------------------
package kmc_pkg;
  localparam int MaxClusters = 32;
  localparam int MaxPoints   = 1024;
  localparam int CoordBits   = 16;
  localparam int LabelBits   = $clog2(MaxClusters);
  localparam int PointBits   = $clog2(MaxPoints);
  localparam int SumBits     = CoordBits + PointBits;
  localparam int CountBits   = PointBits + 1;
  localparam int DistBits    = 2 * (CoordBits + 1) + 2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [2:0] {
    REQ_STORE_POINT  = 3'd0,
    REQ_STORE_CENTER = 3'd1,
    REQ_RUN          = 3'd2,
    REQ_READ_LABEL   = 3'd3,
    REQ_READ_CENTER  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_LABEL  = 2'd1,
    KIND_CENTER = 2'd2
  } kind_t;

  localparam logic [1:0] RegClusters = 2'd0;
  localparam logic [1:0] RegPoints   = 2'd1;
  localparam logic [1:0] RegIters    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_RESP, ST_CLR, ST_AS_RD, ST_AS_CMP, ST_AS_WR,
    ST_ACC_RD, ST_ACC_ADD, ST_UPD_RD, ST_UPD_DIV, ST_UPD_WR, ST_END
  } state_t;

  typedef struct packed {
    logic   start;
    logic   sign;
    logic [SumBits-1:0]   mag;
    logic [CountBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    coord_t quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/kmc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_req_if / kmc_rsp_if: valid-ready channels of the cluster engine
// request channel and result channel with payload
// ----------------------------------------------------------------------------
interface kmc_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic [9:0]          slot;
  kmc_pkg::coord_t     coord_x;
  kmc_pkg::coord_t     coord_y;
  kmc_pkg::coord_t     coord_z;
  modport source (output valid, req_type, slot, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, req_type, slot, coord_x, coord_y, coord_z, output ready);
endinterface

interface kmc_rsp_if;
  logic                valid;
  logic                ready;
  logic [1:0]          result_kind;
  logic [4:0]          label;
  logic [11:0]         iterations_used;
  logic                converged;
  kmc_pkg::coord_t     center_x;
  kmc_pkg::coord_t     center_y;
  kmc_pkg::coord_t     center_z;
  modport source (output valid, result_kind, label, iterations_used, converged,
                  center_x, center_y, center_z, input ready);
  modport sink   (input valid, result_kind, label, iterations_used, converged,
                  center_x, center_y, center_z, output ready);
endinterface
`default_nettype wire

// ===== hdl/kmeans_cluster_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_cluster_engine: Lloyd k-means over stored three-dimensional points
// sequencer with one shared distance unit and one shared serial divider
// ----------------------------------------------------------------------------
// Store point and store center beats are written from ST_IDLE, which stays
// ready for the next request. A label or center read passes ST_RD_WAIT, where
// the result register is loaded, and is then offered as a result beat in
// ST_RESP until the receiver takes it. A run is paced by the single distance
// unit that visits every point/center pair one cycle at a time, by the
// accumulate pass over every point, and by the bit-serial divider, started
// for each coordinate of every center with members. No clearing pass follows
// reset: labels are always written from point 0 upward, so a fill mark tells
// written labels from unwritten ones, and the small center store keeps valid
// bits. The block is not ready during a run.
module kmeans_cluster_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  kmc_req_if.sink          req,
  kmc_rsp_if.source        rsp
);
  localparam int NC = kmc_pkg::MaxClusters;
  localparam int NP = kmc_pkg::MaxPoints;
  localparam int LB = kmc_pkg::LabelBits;
  localparam int PB = kmc_pkg::PointBits;
  localparam int CB = kmc_pkg::CountBits;
  localparam int SB = kmc_pkg::SumBits;
  localparam int DB = kmc_pkg::DistBits;
  localparam int W  = kmc_pkg::CoordBits;

  // configuration registers
  logic [5:0]  num_clusters;
  logic [10:0] num_points;
  logic [11:0] max_iterations;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= 6'd25;
      num_points     <= 11'd1024;
      max_iterations <= 12'd2500;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        kmc_pkg::RegClusters: num_clusters   <= pwdata[5:0];
        kmc_pkg::RegPoints:   num_points     <= pwdata[10:0];
        kmc_pkg::RegIters:    max_iterations <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kmc_pkg::RegClusters: prdata = {26'd0, num_clusters};
      kmc_pkg::RegPoints:   prdata = {21'd0, num_points};
      kmc_pkg::RegIters:    prdata = {20'd0, max_iterations};
      default:              prdata = '0;
    endcase
  end

  // point memory, read data registered
  logic [3*W-1:0] pmem [NP];
  logic [3*W-1:0] pmem_q;
  logic           pmem_we;
  logic [PB-1:0]  pmem_wa;
  logic [PB-1:0]  pmem_ra;

  always_ff @(posedge clk) begin
    if (pmem_we) pmem[pmem_wa] <= {req.coord_x, req.coord_y, req.coord_z};
    pmem_q <= pmem[pmem_ra];
  end

  // label memory with a fill mark (labels below the mark were written,
  // the rest read as zero)
  logic [LB-1:0] lmem [NP];
  logic [LB-1:0] lmem_q;
  logic [PB:0]   lfill;
  logic          lvalid_q;
  logic          lmem_we;
  logic [PB-1:0] lmem_wa;
  logic [LB-1:0] lmem_wd;
  logic [PB-1:0] lmem_ra;

  always_ff @(posedge clk) begin
    if (lmem_we) lmem[lmem_wa] <= lmem_wd;
    lmem_q <= lmem[lmem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) lfill <= '0;
    else if (lmem_we && {1'b0, lmem_wa} >= lfill) lfill <= {1'b0, lmem_wa} + 1'b1;
  end

  always_ff @(posedge clk) lvalid_q <= ({1'b0, lmem_ra} < lfill);

  // centers and per-cluster sums kept as memories
  logic [3*W-1:0] cmem [NC];
  logic [NC-1:0]  cvalid;
  logic [3*W-1:0] cmem_q;
  logic           cvalid_q;
  logic           cmem_we;
  logic [LB-1:0]  cmem_wa;
  logic [3*W-1:0] cmem_wd;
  logic [LB-1:0]  cmem_ra;

  always_ff @(posedge clk) begin
    if (cmem_we) cmem[cmem_wa] <= cmem_wd;
    cmem_q <= cmem[cmem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) cvalid <= '0;
    else if (cmem_we) cvalid[cmem_wa] <= 1'b1;
  end

  always_ff @(posedge clk) cvalid_q <= cvalid[cmem_ra];

  logic [3*SB+CB-1:0] smem [NC];
  logic [3*SB+CB-1:0] smem_q;
  logic               smem_we;
  logic [LB-1:0]      smem_wa;
  logic [3*SB+CB-1:0] smem_wd;
  logic [LB-1:0]      smem_ra;

  always_ff @(posedge clk) begin
    if (smem_we) smem[smem_wa] <= smem_wd;
    smem_q <= smem[smem_ra];
  end

  // sequencer
  kmc_pkg::state_t state, state_next;
  logic [PB:0]     pidx;
  logic [LB:0]     cidx;
  logic [LB:0]     kk;
  logic [PB:0]     nn;
  logic [11:0]     rounds;
  logic            moved;
  logic            conv;
  logic [DB-1:0]   best_d;
  logic [LB-1:0]   best_c;
  logic [1:0]      axis;
  kmc_pkg::coord_t nq_x, nq_y;
  logic [2:0]      req_q;
  logic [9:0]      slot_q;
  logic            accept;

  // response register
  logic [1:0]  o_kind;
  logic [4:0]  o_label;
  logic [11:0] o_iters;
  logic        o_conv;
  kmc_pkg::coord_t o_cx, o_cy, o_cz;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == kmc_pkg::ST_IDLE);
  assign rsp.valid = (state == kmc_pkg::ST_RESP);
  assign rsp.result_kind     = o_kind;
  assign rsp.label           = o_label;
  assign rsp.iterations_used = o_iters;
  assign rsp.converged       = o_conv;
  assign rsp.center_x        = o_cx;
  assign rsp.center_y        = o_cy;
  assign rsp.center_z        = o_cz;

  // shared distance unit: point (pmem_q) against center (cmem_q, zero if unwritten)
  kmc_pkg::coord_t px, py, pz, cx, cy, cz;
  logic signed [W:0] dx, dy, dz;
  logic [DB-1:0]     sq_dist;
  assign {px, py, pz} = pmem_q;
  assign {cx, cy, cz} = cvalid_q ? cmem_q : '0;
  assign dx = {px[W-1], px} - {cx[W-1], cx};
  assign dy = {py[W-1], py} - {cy[W-1], cy};
  assign dz = {pz[W-1], pz} - {cz[W-1], cz};
  assign sq_dist = DB'(dx * dx) + DB'(dy * dy) + DB'(dz * dz);

  // accumulation operands
  logic [SB-1:0] sx, sy, sz;
  logic [CB-1:0] scnt;
  logic [LB-1:0] lab_cur;
  assign {sx, sy, sz, scnt} = smem_q;
  assign lab_cur = lvalid_q ? lmem_q : '0;

  // divider
  kmc_pkg::div_req_t dreq;
  kmc_pkg::div_rsp_t drsp;
  logic [SB-1:0]     dsum;
  kmc_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    case (axis)
      2'd0:    dsum = sx;
      2'd1:    dsum = sy;
      default: dsum = sz;
    endcase
  end

  logic [3*W-1:0] new_c;
  assign new_c = (scnt == 0) ? '0 : {nq_x, nq_y, drsp.quot};

  always_comb begin
    state_next = state;
    pmem_we = 1'b0;  pmem_wa = req.slot[PB-1:0];
    pmem_ra = pidx[PB-1:0];
    lmem_we = 1'b0;  lmem_wa = pidx[PB-1:0]; lmem_wd = best_c;
    lmem_ra = pidx[PB-1:0];
    cmem_we = 1'b0;  cmem_wa = cidx[LB-1:0];
    cmem_wd = {req.coord_x, req.coord_y, req.coord_z};
    cmem_ra = cidx[LB-1:0];
    smem_we = 1'b0;  smem_wa = cidx[LB-1:0]; smem_wd = '0;
    smem_ra = cidx[LB-1:0];
    dreq.start = 1'b0;
    dreq.sign  = dsum[SB-1];
    dreq.mag   = dsum[SB-1] ? (~dsum + 1'b1) : dsum;
    dreq.den   = scnt;
    case (state)
      kmc_pkg::ST_IDLE: begin
        lmem_ra = req.slot[PB-1:0];
        cmem_ra = req.slot[LB-1:0];
        if (accept) begin
          case (req.req_type)
            kmc_pkg::REQ_STORE_POINT: pmem_we = 1'b1;
            kmc_pkg::REQ_STORE_CENTER: begin
              cmem_wa = req.slot[LB-1:0];
              cmem_we = (req.slot < 10'(NC));
            end
            kmc_pkg::REQ_RUN: state_next = kmc_pkg::ST_CLR;
            kmc_pkg::REQ_READ_LABEL, kmc_pkg::REQ_READ_CENTER:
              state_next = kmc_pkg::ST_RD_WAIT;
            default: ;
          endcase
        end
      end
      kmc_pkg::ST_RD_WAIT: state_next = kmc_pkg::ST_RESP;
      kmc_pkg::ST_RESP: if (rsp.ready) state_next = kmc_pkg::ST_IDLE;
      kmc_pkg::ST_CLR: begin
        smem_we = 1'b1;
        if (cidx == kk - 1'b1) state_next = kmc_pkg::ST_AS_RD;
        if (rounds >= max_iterations || conv) state_next = kmc_pkg::ST_END;
      end
      kmc_pkg::ST_AS_RD: begin
        // leaving the assign pass: fetch the label of point 0 ahead
        if (pidx >= nn) lmem_ra = '0;
        if (pidx >= nn) state_next = kmc_pkg::ST_ACC_RD;
        else state_next = kmc_pkg::ST_AS_CMP;
      end
      kmc_pkg::ST_AS_CMP: begin
        if (cidx == kk) state_next = kmc_pkg::ST_AS_WR;
      end
      kmc_pkg::ST_AS_WR: begin
        lmem_we = 1'b1;
        state_next = kmc_pkg::ST_AS_RD;
      end
      kmc_pkg::ST_ACC_RD: begin
        smem_ra = lab_cur;
        if (pidx >= nn) state_next = kmc_pkg::ST_UPD_RD;
        else state_next = kmc_pkg::ST_ACC_ADD;
      end
      kmc_pkg::ST_ACC_ADD: begin
        // label of the next point lands for the next sum read
        lmem_ra = PB'(pidx + 1'b1);
        smem_wa = lab_cur;
        smem_wd = {sx + SB'(signed'(px)), sy + SB'(signed'(py)),
                   sz + SB'(signed'(pz)), scnt + 1'b1};
        smem_we = 1'b1;
        state_next = kmc_pkg::ST_ACC_RD;
      end
      kmc_pkg::ST_UPD_RD: begin
        if (cidx == kk) state_next = kmc_pkg::ST_CLR;
        else state_next = kmc_pkg::ST_UPD_DIV;
      end
      kmc_pkg::ST_UPD_DIV: begin
        if (scnt == 0) state_next = kmc_pkg::ST_UPD_WR;
        else if (!drsp.busy && !drsp.done) dreq.start = 1'b1;
        else if (drsp.done && axis == 2'd2) state_next = kmc_pkg::ST_UPD_WR;
      end
      kmc_pkg::ST_UPD_WR: begin
        cmem_wd = new_c;
        cmem_we = 1'b1;
        state_next = kmc_pkg::ST_UPD_RD;
      end
      kmc_pkg::ST_END: state_next = kmc_pkg::ST_RESP;
      default: state_next = kmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kmc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // sequencer counters and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds <= '0;
      conv   <= 1'b0;
    end else begin
      case (state)
        kmc_pkg::ST_IDLE: begin
          req_q  <= req.req_type;
          slot_q <= req.slot;
          pidx   <= '0;
          cidx   <= '0;
          if (accept && req.req_type == kmc_pkg::REQ_RUN) begin
            rounds <= '0;
            conv   <= 1'b0;
            moved  <= 1'b0;
          end
          if (num_clusters == 0) kk <= (LB+1)'(1);
          else if (num_clusters > 6'(NC)) kk <= (LB+1)'(NC);
          else kk <= (LB+1)'(num_clusters);
          nn <= (num_points > 11'(NP)) ? (PB+1)'(NP) : (PB+1)'(num_points);
        end
        kmc_pkg::ST_RD_WAIT: begin
          o_kind  <= (req_q == kmc_pkg::REQ_READ_LABEL) ? kmc_pkg::KIND_LABEL
                                                       : kmc_pkg::KIND_CENTER;
          o_iters <= '0;
          o_conv  <= 1'b0;
          o_label <= '0;
          {o_cx, o_cy, o_cz} <= '0;
          if (req_q == kmc_pkg::REQ_READ_LABEL) begin
            if ({1'b0, slot_q} < 11'(NP)) o_label <= 5'(lab_cur);
          end else if (slot_q < 10'(NC)) begin
            {o_cx, o_cy, o_cz} <= cvalid_q ? cmem_q : '0;
          end
        end
        kmc_pkg::ST_CLR: begin
          // no new round once the run is over
          if (rounds < max_iterations && !conv) begin
            cidx <= cidx + 1'b1;
            if (cidx == kk - 1'b1) begin
              cidx   <= '0;
              pidx   <= '0;
              rounds <= rounds + 1'b1;
              moved  <= 1'b0;
            end
          end
        end
        kmc_pkg::ST_AS_RD: begin
          cidx   <= '0;
          best_d <= '1;
          if (pidx >= nn) pidx <= '0;
        end
        kmc_pkg::ST_AS_CMP: begin
          // cidx addresses the center read in flight; compare the one landed
          if (cidx != 0 && (cidx == 1 || sq_dist < best_d)) begin
            best_d <= sq_dist;
            best_c <= LB'(cidx - 1'b1);
          end
          if (cidx != kk) cidx <= cidx + 1'b1;
        end
        kmc_pkg::ST_AS_WR: pidx <= pidx + 1'b1;
        kmc_pkg::ST_ACC_RD: if (pidx >= nn) cidx <= '0;
        kmc_pkg::ST_ACC_ADD: pidx <= pidx + 1'b1;
        kmc_pkg::ST_UPD_RD: begin
          axis <= 2'd0;
          if (cidx == kk) begin
            cidx <= '0;
            conv <= !moved;
          end
        end
        kmc_pkg::ST_UPD_DIV: begin
          if (drsp.done) begin
            if (axis == 2'd0) nq_x <= drsp.quot;
            if (axis == 2'd1) nq_y <= drsp.quot;
            if (axis != 2'd2) axis <= axis + 1'b1;
          end
        end
        kmc_pkg::ST_UPD_WR: begin
          if (new_c != (cvalid_q ? cmem_q : '0)) moved <= 1'b1;
          cidx <= cidx + 1'b1;
        end
        kmc_pkg::ST_END: begin
          o_kind  <= kmc_pkg::KIND_RUN;
          o_iters <= rounds;
          o_conv  <= conv;
          o_label <= '0;
          {o_cx, o_cy, o_cz} <= '0;
        end
        default: ;
      endcase
    end
  end

  // the assign step leads the compare by the registered point and center reads
  // (cidx 0 issues center 0; cidx 1 compares it), handled above

  // the result beat is only offered after a request was taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == kmc_pkg::ST_RD_WAIT || $past(state) == kmc_pkg::ST_END)
    else $error("result beat without request");
  // no new request is taken while a result waits
  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> !req.ready)
    else $error("request taken while result pending");
  // the divider is only started when idle
  assert property (@(posedge clk) disable iff (rst) dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");
  // round count never exceeds the limit
  assert property (@(posedge clk) disable iff (rst)
    state == kmc_pkg::ST_END |-> rounds <= max_iterations)
    else $error("round limit overrun");
endmodule
`default_nettype wire

// ===== hdl/kmc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_divider: shared restoring divider
// one quotient bit per cycle, magnitude over count, sign applied at the end
// ----------------------------------------------------------------------------
module kmc_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kmc_pkg::div_req_t req,
  output kmc_pkg::div_rsp_t      rsp
);
  localparam int SB = kmc_pkg::SumBits;
  localparam int CB = kmc_pkg::CountBits;

  logic [SB-1:0]   quo;
  logic [CB:0]     rem;
  logic [CB-1:0]   den;
  logic            sign;
  logic [$clog2(SB+1)-1:0] cnt;
  logic            busy;
  logic            done;
  logic [CB:0]     trial;
  logic [SB-1:0]   q_signed;

  assign trial = {rem[CB-1:0], quo[SB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(SB+1))'(SB);
        quo  <= req.mag;
        rem  <= '0;
        den  <= req.den;
        sign <= req.sign;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[SB-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[SB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q_signed  = sign ? (~quo + 1'b1) : quo;
  assign rsp.busy  = busy;
  assign rsp.done  = done;
  assign rsp.quot  = q_signed[kmc_pkg::CoordBits-1:0];
endmodule
`default_nettype wire
